// ===== design/fbpa_pkg.sv =====
// shared constants for the fixed block pool allocator
package fbpa_pkg;

	localparam int POINTER_BYTES       = 8;
	localparam int MAX_PAGES           = 16;
	localparam int MAX_BLOCKS_PER_PAGE = 64;
	localparam int ADDRESS_BITS        = 24;
	localparam int STACK_CAP           = MAX_PAGES * MAX_BLOCKS_PER_PAGE;
	localparam int STACK_AW            = $clog2(STACK_CAP);
	localparam int DEPTH_W             = STACK_AW + 1;
	localparam int USE_W               = 11;
	localparam int OBJ_MAX             = 4096;

	// geometry widths
	localparam int IC_W   = 10;
	localparam int DC_W   = 13;
	localparam int PS_W   = 19;
	localparam int PAGE_W = 5;
	localparam int BPP_W  = 7;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_PAGES  = 3'd1;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
	localparam logic [2:0] ST_BAD_BOUND = 3'd3;
	localparam logic [2:0] ST_MULTI     = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	// request types
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// register indexes
	localparam logic [2:0] REG_OBJ    = 3'd0;
	localparam logic [2:0] REG_PAD    = 3'd1;
	localparam logic [2:0] REG_HDR    = 3'd2;
	localparam logic [2:0] REG_BPP    = 3'd3;
	localparam logic [2:0] REG_LIMIT  = 3'd4;
	localparam logic [2:0] REG_CHECKS = 3'd5;

endpackage

// ===== design/fixed_block_pool_allocator.sv =====
// fixed block pool allocator: register file, free stack and request sequencer
//
// One request (allocate or free) is taken at a time and answered with one result
// item carrying a status and all usage counters. A small sequencer steps each
// request through the datapath registers. Every request is first taken, then works
// out the block geometry from the registers in S_GEO1 to S_GEO3, passes a dispatch
// state and ends in a final state that loads the result register. An allocate with
// blocks on the stack reads the stack before the final state; an allocate refused
// for lack of pages goes straight from dispatch to the final state; an allocate that
// opens a page first walks the page bases of the open pages and then pushes
// blocks_per_page blocks. An unchecked free goes straight to the push. A checked free
// walks the pages to find the one that holds the address, steps down the in-page
// offset by the block stride, then reads the free stack entry by entry for the
// double free search before the push, so its cost grows with the stack depth. The
// stack is a 1024 x 24 memory with one write and one registered read port, which
// sets the scan rate. The result waits in an output register, so a new request is
// taken while the previous result is still stalled; the final state of the next
// request waits until that register is free. Stack entries are never cleared after
// reset; only entries below the stack depth are ever read.
module fixed_block_pool_allocator import fbpa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    req_type,
	input  logic [ADDRESS_BITS-1:0] free_address,
	// result channel
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [2:0]              status,
	output logic [ADDRESS_BITS-1:0] block_address,
	output logic [USE_W-1:0]        blocks_in_use,
	output logic [USE_W-1:0]        blocks_free,
	output logic [PAGE_W-1:0]       pages_open,
	output logic [USE_W-1:0]        peak_in_use,
	output logic [31:0]             alloc_count,
	output logic [31:0]             free_count,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_GEO1  = 4'd1;
	localparam logic [3:0] S_GEO2  = 4'd2;
	localparam logic [3:0] S_GEO3  = 4'd3;
	localparam logic [3:0] S_DISP  = 4'd4;
	localparam logic [3:0] S_BASE  = 4'd5;
	localparam logic [3:0] S_PUSH  = 4'd6;
	localparam logic [3:0] S_POP   = 4'd7;
	localparam logic [3:0] S_POPW  = 4'd8;
	localparam logic [3:0] S_PAGE  = 4'd9;
	localparam logic [3:0] S_MODS  = 4'd10;
	localparam logic [3:0] S_SCANR = 4'd11;
	localparam logic [3:0] S_SCANC = 4'd12;
	localparam logic [3:0] S_FULL  = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	// configuration registers
	logic [12:0] obj_q;
	logic [7:0]  pad_q;
	logic [7:0]  hdr_q;
	logic [6:0]  bpp_q;
	logic [4:0]  limit_q;
	logic        checks_q;

	// allocator state
	logic [DEPTH_W-1:0] depth_q;
	logic [PAGE_W-1:0]  open_q;
	logic [USE_W-1:0]   use_q;
	logic [USE_W-1:0]   peak_q;
	logic [31:0]        allocs_q;
	logic [31:0]        frees_q;

	// sequencer registers
	logic [3:0]              state_q;
	logic                    type_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [IC_W-1:0]         ic_q;
	logic [DC_W-1:0]         dc_q;
	logic [PS_W-1:0]         prod_q;
	logic [PS_W-1:0]         ps_q;
	logic [ADDRESS_BITS-1:0] acc_q;
	logic [PS_W-1:0]         rem_q;
	logic [DEPTH_W-1:0]      idx_q;
	logic [2:0]              st_q;
	logic [ADDRESS_BITS-1:0] given_q;

	// output registers
	logic                    rsp_valid_q;
	logic [2:0]              status_q;
	logic [ADDRESS_BITS-1:0] baddr_q;
	logic [USE_W-1:0]        o_use_q;
	logic [USE_W-1:0]        o_free_q;
	logic [PAGE_W-1:0]       o_open_q;
	logic [USE_W-1:0]        o_peak_q;
	logic [31:0]             o_allocs_q;
	logic [31:0]             o_frees_q;

	// free stack
	logic [ADDRESS_BITS-1:0] stack_mem [STACK_CAP];
	logic [ADDRESS_BITS-1:0] rdata_q;
	logic                    mem_we;
	logic [STACK_AW-1:0]     mem_waddr;
	logic [ADDRESS_BITS-1:0] mem_wdata;
	logic [STACK_AW-1:0]     mem_raddr;

	// clamped registers
	logic [12:0] obj_eff;
	logic [6:0]  bpp_eff;
	logic [4:0]  limit_eff;

	logic cfg_wr;
	logic req_acc;
	logic [PAGE_W-1:0] pcnt_q;
	logic [BPP_W-1:0]  bcnt_q;

	always_comb begin
		if (obj_q == 13'd0) begin
			obj_eff = 13'd1;
		end else if (obj_q > 13'(OBJ_MAX)) begin
			obj_eff = 13'(OBJ_MAX);
		end else begin
			obj_eff = obj_q;
		end
		if (bpp_q == 7'd0) begin
			bpp_eff = 7'd1;
		end else if (bpp_q > 7'(MAX_BLOCKS_PER_PAGE)) begin
			bpp_eff = 7'(MAX_BLOCKS_PER_PAGE);
		end else begin
			bpp_eff = bpp_q;
		end
		limit_eff = (limit_q > 5'(MAX_PAGES)) ? 5'(MAX_PAGES) : limit_q;
	end

	// register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_q    <= 13'd16;
			pad_q    <= 8'd0;
			hdr_q    <= 8'd0;
			bpp_q    <= 7'd4;
			limit_q  <= 5'd2;
			checks_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_OBJ:    obj_q    <= pwdata[12:0];
				REG_PAD:    pad_q    <= pwdata[7:0];
				REG_HDR:    hdr_q    <= pwdata[7:0];
				REG_BPP:    bpp_q    <= pwdata[6:0];
				REG_LIMIT:  limit_q  <= pwdata[4:0];
				REG_CHECKS: checks_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_OBJ:    prdata = {19'd0, obj_q};
			REG_PAD:    prdata = {24'd0, pad_q};
			REG_HDR:    prdata = {24'd0, hdr_q};
			REG_BPP:    prdata = {25'd0, bpp_q};
			REG_LIMIT:  prdata = {27'd0, limit_q};
			REG_CHECKS: prdata = {31'd0, checks_q};
			default:    prdata = 32'd0;
		endcase
	end

	// handshakes: a request is taken only while the sequencer is idle
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;

	// stack memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = depth_q[STACK_AW-1:0];
		mem_wdata = acc_q;
		mem_raddr = idx_q[STACK_AW-1:0];
		case (state_q)
			S_PUSH: mem_we = 1'b1;
			S_FULL: begin
				mem_we    = !depth_q[DEPTH_W-1];
				mem_wdata = addr_q;
			end
			S_POP:  mem_raddr = STACK_AW'(depth_q - 1'b1);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= stack_mem[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			open_q      <= '0;
			use_q       <= '0;
			peak_q      <= '0;
			allocs_q    <= '0;
			frees_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_GEO1;
					end
				end
				S_GEO1: state_q <= S_GEO2;
				S_GEO2: state_q <= S_GEO3;
				S_GEO3: state_q <= S_DISP;
				S_DISP: begin
					if (type_q == REQ_ALLOC) begin
						if (depth_q != '0) begin
							state_q <= S_POP;
						end else if (open_q >= limit_eff) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_BASE;
						end
					end else if (checks_q) begin
						state_q <= S_PAGE;
					end else begin
						state_q <= S_FULL;
					end
				end
				S_BASE: begin
					if (pcnt_q == open_q) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					depth_q <= depth_q + 1'b1;
					if (bcnt_q == bpp_eff - 1'b1) begin
						open_q  <= open_q + 1'b1;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					depth_q <= depth_q - 1'b1;
					state_q <= S_POPW;
				end
				S_POPW: begin
					allocs_q <= allocs_q + 1'b1;
					if (use_q != '1) begin
						use_q <= use_q + 1'b1;
						if (use_q + 1'b1 > peak_q) begin
							peak_q <= use_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_PAGE: begin
					if (pcnt_q == open_q) begin
						state_q <= S_DONE;
					end else if (acc_q < ADDRESS_BITS'(ps_q)) begin
						if (acc_q < ADDRESS_BITS'(ic_q)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MODS;
						end
					end
				end
				S_MODS: begin
					if (rem_q == '0) begin
						state_q <= S_SCANR;
					end else if (rem_q < PS_W'(dc_q)) begin
						state_q <= S_DONE;
					end
				end
				S_SCANR: begin
					state_q <= (idx_q == depth_q) ? S_FULL : S_SCANC;
				end
				S_SCANC: begin
					state_q <= (rdata_q == addr_q) ? S_DONE : S_SCANR;
				end
				S_FULL: begin
					if (!depth_q[DEPTH_W-1]) begin
						depth_q <= depth_q + 1'b1;
						frees_q <= frees_q + 1'b1;
						if (use_q != '0) begin
							use_q <= use_q - 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, updated according to the sequencer state
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				type_q  <= req_type;
				addr_q  <= free_address;
				st_q    <= ST_OK;
				given_q <= '0;
			end
			S_GEO1: begin
				ic_q <= IC_W'(POINTER_BYTES) + IC_W'(hdr_q) + IC_W'(pad_q);
				dc_q <= obj_eff + {pad_q, 1'b0} + DC_W'(hdr_q);
			end
			S_GEO2: prod_q <= PS_W'(bpp_eff - 1'b1) * PS_W'(dc_q);
			S_GEO3: ps_q <= prod_q + PS_W'(ic_q) + PS_W'(obj_eff) + PS_W'(pad_q);
			S_DISP: begin
				pcnt_q <= '0;
				bcnt_q <= '0;
				idx_q  <= '0;
				if (type_q == REQ_ALLOC) begin
					acc_q <= ADDRESS_BITS'(ic_q);
					if (depth_q == '0 && open_q >= limit_eff) begin
						st_q <= ST_NO_PAGES;
					end
				end else begin
					acc_q <= addr_q;
				end
			end
			S_BASE: begin
				if (pcnt_q != open_q) begin
					acc_q  <= acc_q + ADDRESS_BITS'(ps_q);
					pcnt_q <= pcnt_q + 1'b1;
				end
			end
			S_PUSH: begin
				acc_q  <= acc_q + ADDRESS_BITS'(dc_q);
				bcnt_q <= bcnt_q + 1'b1;
			end
			S_POPW: given_q <= rdata_q;
			S_PAGE: begin
				if (pcnt_q == open_q) begin
					st_q <= ST_BAD_ADDR;
				end else if (acc_q < ADDRESS_BITS'(ps_q)) begin
					if (acc_q < ADDRESS_BITS'(ic_q)) begin
						st_q <= ST_BAD_BOUND;
					end
					rem_q <= PS_W'(acc_q - ADDRESS_BITS'(ic_q));
				end else begin
					acc_q  <= acc_q - ADDRESS_BITS'(ps_q);
					pcnt_q <= pcnt_q + 1'b1;
				end
			end
			S_MODS: begin
				if (rem_q != '0) begin
					if (rem_q < PS_W'(dc_q)) begin
						st_q <= ST_BAD_BOUND;
					end else begin
						rem_q <= rem_q - PS_W'(dc_q);
					end
				end
			end
			S_SCANC: begin
				idx_q <= idx_q + 1'b1;
				if (rdata_q == addr_q) begin
					st_q <= ST_MULTI;
				end
			end
			S_FULL: begin
				if (depth_q[DEPTH_W-1]) begin
					st_q <= ST_FULL;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					status_q   <= st_q;
					baddr_q    <= given_q;
					o_use_q    <= use_q;
					o_free_q   <= USE_W'(depth_q);
					o_open_q   <= open_q;
					o_peak_q   <= peak_q;
					o_allocs_q <= allocs_q;
					o_frees_q  <= frees_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign block_address = baddr_q;
	assign blocks_in_use = o_use_q;
	assign blocks_free   = o_free_q;
	assign pages_open    = o_open_q;
	assign peak_in_use   = o_peak_q;
	assign alloc_count   = o_allocs_q;
	assign free_count    = o_frees_q;

endmodule

// ===== design/fbpa_checker.sv =====
// port level checks for the fixed block pool allocator
module fbpa_checker import fbpa_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_stall,
	input logic                    rsp_valid,
	input logic                    rsp_stall,
	input logic [2:0]              status,
	input logic [ADDRESS_BITS-1:0] block_address,
	input logic [USE_W-1:0]        blocks_in_use,
	input logic [USE_W-1:0]        peak_in_use
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(block_address))
		else $error("stalled result changed");

	// failed requests hand out no address
	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> block_address == '0)
		else $error("address on failed request");

	// peak never below current use
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> peak_in_use >= blocks_in_use)
		else $error("peak below use");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

// ===== sim/tb_top.sv =====
// self-checking testbench for the fixed block pool allocator
module tb_top import fbpa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 20000000;
	localparam int USE_SAT = 2047;

	// one request item as it goes into the block
	typedef struct packed {
		logic                    kind;
		logic [ADDRESS_BITS-1:0] addr;
	} request_t;

	// one result item as the block should answer it
	typedef struct packed {
		logic [2:0]              status;
		logic [ADDRESS_BITS-1:0] block_address;
		logic [USE_W-1:0]        in_use;
		logic [USE_W-1:0]        free_blocks;
		logic [PAGE_W-1:0]       pages;
		logic [USE_W-1:0]        peak;
		logic [31:0]             allocs;
		logic [31:0]             frees;
	} result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	logic                    req_type;
	logic [ADDRESS_BITS-1:0] free_address;
	logic                    rsp_valid;
	logic                    rsp_stall;
	logic [2:0]              status;
	logic [ADDRESS_BITS-1:0] block_address;
	logic [USE_W-1:0]        blocks_in_use;
	logic [USE_W-1:0]        blocks_free;
	logic [PAGE_W-1:0]       pages_open;
	logic [USE_W-1:0]        peak_in_use;
	logic [31:0]             alloc_count;
	logic [31:0]             free_count;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [4:0]              paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;

	fixed_block_pool_allocator u_top (.*);

	// request items waiting for the driver, result items the block still owes
	request_t request_q[$];
	result_t  owed_results[$];

	// shadow of the registers as last written
	logic [12:0] obj_reg;
	logic [7:0]  pad_reg;
	logic [7:0]  hdr_reg;
	logic [6:0]  bpp_reg;
	logic [4:0]  limit_reg;
	logic        checks_reg;

	// shadow of the allocator state
	logic [ADDRESS_BITS-1:0] pool_stack[STACK_CAP];
	int unsigned             pool_depth;
	int unsigned             pages_used;
	int unsigned             used_now;
	int unsigned             used_peak;
	logic [31:0]             n_allocs;
	logic [31:0]             n_frees;

	// addresses currently held by the stimulus side, used for well-formed frees
	logic [ADDRESS_BITS-1:0] held_blocks[$];

	int     send_idle_pct;
	int     stall_pct;
	logic   req_taken;
	int     fail_count;
	longint cycle_count;
	request_t next_req;

	// clock, 12 ns period
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// --- geometry from the current registers, with the register clamps applied
	function automatic longint unsigned eff_obj();
		if (obj_reg == 0) return 1;
		return (obj_reg > OBJ_MAX) ? OBJ_MAX : obj_reg;
	endfunction

	function automatic longint unsigned eff_bpp();
		if (bpp_reg == 0) return 1;
		return (bpp_reg > MAX_BLOCKS_PER_PAGE) ? MAX_BLOCKS_PER_PAGE : bpp_reg;
	endfunction

	function automatic longint unsigned first_offset();
		return POINTER_BYTES + hdr_reg + pad_reg;
	endfunction

	function automatic longint unsigned block_stride();
		return eff_obj() + 2 * pad_reg + hdr_reg;
	endfunction

	function automatic longint unsigned page_bytes();
		return first_offset() + (eff_bpp() - 1) * block_stride() + eff_obj() + pad_reg;
	endfunction

	// free-time address and double free checks
	function automatic logic [2:0] vet_free(input logic [ADDRESS_BITS-1:0] addr);
		longint unsigned ps, pg, off, ic;
		ps = page_bytes();
		pg = addr / ps;
		if (pg >= pages_used) return ST_BAD_ADDR;
		off = addr - pg * ps;
		ic = first_offset();
		if (off < ic || ((off - ic) % block_stride()) != 0) return ST_BAD_BOUND;
		for (int i = 0; i < pool_depth; i++)
			if (pool_stack[i] == addr) return ST_MULTI;
		return ST_OK;
	endfunction

	// serves one request on the shadow state and returns the result it causes
	function automatic result_t serve_request(input logic kind,
	                                          input logic [ADDRESS_BITS-1:0] addr);
		result_t r;
		logic [2:0] st;
		longint unsigned base, lim;
		logic [ADDRESS_BITS-1:0] given;
		st = ST_OK;
		given = '0;
		if (kind == REQ_ALLOC) begin
			lim = (limit_reg > MAX_PAGES) ? MAX_PAGES : limit_reg;
			if (pool_depth == 0) begin
				if (pages_used >= lim) begin
					st = ST_NO_PAGES;
				end else begin
					// last block of the new page ends up on top
					base = pages_used * page_bytes() + first_offset();
					for (longint unsigned b = 0; b < eff_bpp() && pool_depth < STACK_CAP; b++) begin
						pool_stack[pool_depth] = ADDRESS_BITS'(base + b * block_stride());
						pool_depth++;
					end
					pages_used++;
				end
			end
			if (st == ST_OK && pool_depth > 0) begin
				pool_depth--;
				given = pool_stack[pool_depth];
				n_allocs++;
				if (used_now < USE_SAT) used_now++;
				if (used_now > used_peak) used_peak = used_now;
			end
		end else begin
			if (checks_reg) st = vet_free(addr);
			if (st == ST_OK && pool_depth >= STACK_CAP) st = ST_FULL;
			if (st == ST_OK) begin
				pool_stack[pool_depth] = addr;
				pool_depth++;
				n_frees++;
				if (used_now > 0) used_now--;
			end
		end
		r.status        = st;
		r.block_address = given;
		r.in_use        = USE_W'(used_now);
		r.free_blocks   = USE_W'(pool_depth);
		r.pages         = PAGE_W'(pages_used);
		r.peak          = USE_W'(used_peak);
		r.allocs        = n_allocs;
		r.frees         = n_frees;
		return r;
	endfunction

	// queues one request and the result it is owed, tracking held blocks
	task automatic issue(input logic kind, input logic [ADDRESS_BITS-1:0] addr);
		result_t r;
		r = serve_request(kind, addr);
		owed_results.push_back(r);
		request_q.push_back('{kind: kind, addr: addr});
		if (kind == REQ_ALLOC && r.status == ST_OK) held_blocks.push_back(r.block_address);
	endtask

	// one random request, mostly well-formed alloc/free traffic
	task automatic issue_random();
		int pick, idx;
		logic [ADDRESS_BITS-1:0] a;
		pick = $urandom_range(99);
		a = ADDRESS_BITS'($urandom);
		if (pick < 45) begin
			issue(REQ_ALLOC, a);
		end else if (pick < 80 && held_blocks.size() > 0) begin
			idx = $urandom_range(held_blocks.size() - 1);
			a = held_blocks[idx];
			held_blocks.delete(idx);
			issue(REQ_FREE, a);
		end else if (pick < 88 && pool_depth > 0) begin
			// double free of a block already on the stack
			issue(REQ_FREE, pool_stack[$urandom_range(pool_depth - 1)]);
		end else if (pick < 94) begin
			// near a block boundary inside some page
			a = ADDRESS_BITS'($urandom_range(16) * page_bytes() + first_offset()
				+ $urandom_range(eff_bpp()) * block_stride() + $urandom_range(2) - 1);
			issue(REQ_FREE, a);
		end else begin
			issue(REQ_FREE, a);
		end
	endtask

	// register write, setup then access cycle
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx * 4);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_OBJ:    obj_reg    = value[12:0];
			REG_PAD:    pad_reg    = value[7:0];
			REG_HDR:    hdr_reg    = value[7:0];
			REG_BPP:    bpp_reg    = value[6:0];
			REG_LIMIT:  limit_reg  = value[4:0];
			REG_CHECKS: checks_reg = value[0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int obj, input int pad, input int hdr,
	                            input int bpp, input int lim, input int chk);
		reg_write(REG_OBJ, obj);
		reg_write(REG_PAD, pad);
		reg_write(REG_HDR, hdr);
		reg_write(REG_BPP, bpp);
		reg_write(REG_LIMIT, lim);
		reg_write(REG_CHECKS, chk);
	endtask

	// block until every item is in and every result is out, then let it settle
	task automatic wait_drained();
		while (request_q.size() > 0 || owed_results.size() > 0 || req_valid)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 59; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 59; end
			default: begin send_idle_pct = 29; stall_pct = 29; end
		endcase
	endtask

	// request driver, changes inputs on the falling edge
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = request_q.pop_front();
				req_valid    <= 1'b1;
				req_type     <= next_req.kind;
				free_address <= next_req.addr;
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk)
		req_taken <= req_valid && !req_stall;

	task automatic compare_field(input string name, input logic [31:0] want,
	                             input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// result monitor, samples on the rising edge
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_results.size() == 0) begin
				$error("result item with nothing owed");
				fail_count++;
			end else begin
				compare_field("status", 32'(owed_results[0].status), 32'(status));
				compare_field("block_address", 32'(owed_results[0].block_address),
					32'(block_address));
				compare_field("blocks_in_use", 32'(owed_results[0].in_use),
					32'(blocks_in_use));
				compare_field("blocks_free", 32'(owed_results[0].free_blocks),
					32'(blocks_free));
				compare_field("pages_open", 32'(owed_results[0].pages), 32'(pages_open));
				compare_field("peak_in_use", 32'(owed_results[0].peak), 32'(peak_in_use));
				compare_field("alloc_count", owed_results[0].allocs, alloc_count);
				compare_field("free_count", owed_results[0].frees, free_count);
				void'(owed_results.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_ALLOC;
		free_address = '0;
		rsp_stall = 1'b0;
		req_taken = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		// reset values of the registers and state
		obj_reg = 16; pad_reg = 0; hdr_reg = 0; bpp_reg = 4; limit_reg = 2; checks_reg = 1;
		pool_depth = 0; pages_used = 0; used_now = 0; used_peak = 0;
		n_allocs = 0; n_frees = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: default geometry, first block at 8, stride 16, page 72 bytes
		issue(REQ_FREE, ADDRESS_BITS'(0));       // no page open yet
		for (int i = 0; i < 8; i++) issue(REQ_ALLOC, '1);
		issue(REQ_ALLOC, ADDRESS_BITS'(0));      // page limit reached
		issue(REQ_FREE, ADDRESS_BITS'(8));
		issue(REQ_FREE, ADDRESS_BITS'(8));       // double free
		issue(REQ_FREE, ADDRESS_BITS'(9));       // off the block boundary
		issue(REQ_FREE, ADDRESS_BITS'(4));       // inside the page header
		issue(REQ_FREE, ADDRESS_BITS'(144));     // past the open pages
		issue(REQ_FREE, '1);                     // top of the address space
		issue(REQ_ALLOC, ADDRESS_BITS'(0));
		issue(REQ_FREE, ADDRESS_BITS'(80));
		issue(REQ_FREE, ADDRESS_BITS'(56));
		wait_drained();

		// random phases through a spread of geometries, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_geometry(0, 0, 0, 0, 4, 1);            // clamps to the minimum
				1: set_geometry(8191, 255, 255, 127, 6, 1);   // clamps to the maximum
				2: set_geometry(100, 3, 7, 5, 0, 1);          // no new pages allowed
				3: set_geometry(37, 1, 2, 8, 10, 0);          // checks off
				default: set_geometry(24, 0, 8, 16, 31, 1);
			endcase
			set_idling(ph);
			for (int i = 0; i < 160; i++) begin
				issue_random();
				// halfway through, hold off until the block has answered everything
				if (i == 80) wait_drained();
			end
			wait_drained();
		end

		// unchecked frees until the stack overflows, then drain a little
		set_geometry(16, 0, 0, 64, 16, 0);
		set_idling(3);
		for (int i = 0; i < 1030; i++) issue(REQ_FREE, ADDRESS_BITS'($urandom));
		for (int i = 0; i < 40; i++) issue(REQ_ALLOC, ADDRESS_BITS'(0));
		wait_drained();

		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== fixed_block_pool_allocator.f =====
design/fbpa_pkg.sv
design/fixed_block_pool_allocator.sv
design/fbpa_checker.sv
sim/tb_top.sv
